>>> rtl/csi_pkg.sv
package csi_pkg;

    // Payload of one request and of one result
    typedef struct packed {
        logic signed [31:0] p1_x;
        logic signed [31:0] p1_y;
        logic signed [31:0] p2_x;
        logic signed [31:0] p2_y;
        logic        [30:0] radius;
    } t_in;

    typedef struct packed {
        logic               found;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
    } t_out;

    // Wide multiplier: operand magnitudes, limb split, pipeline depth
    localparam int MUL_W     = 66;
    localparam int MUL_LIMBS = 3;
    localparam int LIMB_W    = MUL_W / MUL_LIMBS;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_LAT   = 3;

    // Square root of the 128-bit discriminant, one root bit per stage
    localparam int DISC_W    = 128;
    localparam int SQRT_BITS = DISC_W / 2;

    // Numerator and divider
    localparam int NUM_W     = 99;
    localparam int QBITS     = 33;
    localparam int DIV_LAT   = QBITS + 2;

    // Saturation limits as magnitudes
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

>>> rtl/csi_mul.sv
module csi_mul (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [csi_pkg::MUL_W-1:0]    i_a,
    input  logic [csi_pkg::MUL_W-1:0]    i_b,
    output logic [csi_pkg::PROD_W-1:0]   o_p
);
    import csi_pkg::*;

    logic [2*LIMB_W-1:0] r_pp  [MUL_LIMBS][MUL_LIMBS];
    logic [PROD_W-1:0]   r_row [MUL_LIMBS];
    logic [PROD_W-1:0]   r_p;
    logic [PROD_W-1:0]   n_row [MUL_LIMBS];
    logic [PROD_W-1:0]   n_p;

    // Sum partial products of each row, then the rows
    always_comb begin
        n_p = '0;
        for (int i = 0; i < MUL_LIMBS; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < MUL_LIMBS; j++) begin
                n_row[i] = n_row[i] + (PROD_W'(r_pp[i][j]) << (j * LIMB_W));
            end
            n_p = n_p + (r_row[i] << (i * LIMB_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < MUL_LIMBS; i++) begin
                for (int j = 0; j < MUL_LIMBS; j++) begin
                    r_pp[i][j] <= i_a[i*LIMB_W +: LIMB_W] * i_b[j*LIMB_W +: LIMB_W];
                end
                r_row[i] <= n_row[i];
            end
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/csi_div.sv
module csi_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [csi_pkg::NUM_W-1:0]  i_num,
    input  logic        [csi_pkg::MUL_W-1:0]  i_den,
    output logic signed [31:0]                o_q
);
    import csi_pkg::*;

    logic [NUM_W-1:0] r_rem [QBITS+1];
    logic [MUL_W-1:0] r_den [QBITS+1];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic             r_neg [QBITS+1];
    logic             r_ovf [QBITS+1];
    logic [31:0]      r_out;

    logic [NUM_W-1:0] n_mag;
    logic             n_round;
    logic [QBITS:0]   n_qr;
    logic [31:0]      n_lim;
    logic [31:0]      n_res;

    // Take magnitude; flag quotients that cannot fit the result bits
    always_comb begin
        n_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_mag;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[NUM_W-1];
            r_ovf[0] <= {1'b0, n_mag} >= ({(NUM_W+1-MUL_W)'(0), i_den} << QBITS);
        end
    end

    for (genvar k = 0; k < QBITS; k++) begin : g_step
        localparam int B = QBITS - 1 - k;
        logic [NUM_W-1:0] n_trial;
        logic             n_take;
        logic [QBITS-1:0] n_q;

        always_comb begin
            n_trial = {(NUM_W-MUL_W)'(0), r_den[k]} << B;
            n_take  = !r_ovf[k] && (r_rem[k] >= n_trial);
            n_q     = r_q[k];
            n_q[B]  = n_take;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_take ? r_rem[k] - n_trial : r_rem[k];
                r_den[k+1] <= r_den[k];
                r_q[k+1]   <= n_q;
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    // Round half away from zero, saturate, restore sign
    always_comb begin
        n_round = {r_rem[QBITS], 1'b0} >= {(NUM_W+1-MUL_W)'(0), r_den[QBITS]};
        n_qr    = {1'b0, r_q[QBITS]} + (QBITS+1)'(n_round);
        n_lim   = r_neg[QBITS] ? SAT_NEG : SAT_POS;
        if (r_ovf[QBITS] || (n_qr > {(QBITS+1-32)'(0), n_lim})) begin
            n_res = n_lim;
        end else begin
            n_res = n_qr[31:0];
        end
        if (r_neg[QBITS]) begin
            n_res = -n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_res;
        end
    end

    assign o_q = r_out;

endmodule

>>> rtl/circle_segment_intersect_unit.sv
// Lookahead point of a pure-pursuit follower: intersection of the line through
// two points with a circle of given radius centred at the origin, Q16.16.
// Input channel: i_in_valid / o_in_ready carry one request (two points and a
// radius). Output channel: o_out_valid / i_out_ready carry one result (found
// flag and the point, saturated; zero when no point exists or the points
// coincide). Every request yields exactly one result, in order.
// Throughput: one request per cycle unless the output stalls (see below). The
// pipeline is 111 stages: four front stages, the wide multipliers and a hand-off
// stage for the discriminant, the 64 stages of the bit-per-stage square root,
// the wide multipliers and a numerator stage, and the 35 stages of the 33-bit
// restoring divider.
// The whole pipeline advances as one: when a result waits on the output and
// the receiver holds i_out_ready low, every stage holds and o_in_ready is low,
// so nothing is lost or repeated. Bubbles flow through like requests.
// Reset (i_rst_n low at a clock edge) clears all valid bits; no result is
// shown until a new request has passed through.
module circle_segment_intersect_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  csi_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output csi_pkg::t_out o_out_data
);
    import csi_pkg::*;

    localparam int ST_SQ0    = 4 + MUL_LAT;
    localparam int ST_NUM    = ST_SQ0 + SQRT_BITS + 1 + MUL_LAT;
    localparam int TOTAL_LAT = ST_NUM + 1 + DIV_LAT;

    // Convert a product magnitude and its sign to a signed numerator term
    function automatic logic signed [NUM_W-1:0] f_term(input logic [PROD_W-1:0] p,
                                                       input logic neg);
        logic signed [NUM_W-1:0] m;
        m = {2'b00, p[NUM_W-3:0]};
        return neg ? -m : m;
    endfunction

    logic                 n_en;
    logic [TOTAL_LAT-1:0] r_vld;

    // stage 0: input register
    t_in r0_in;

    // stage 1: differences and 32-bit products
    logic signed [32:0] r1_dx, r1_dy;
    logic signed [63:0] r1_p12, r1_p21, r1_sx1, r1_sy1, r1_sx2, r1_sy2;
    logic        [61:0] r1_rr;

    // stage 2: determinant, squares, distances
    logic signed [64:0] r2_det;
    logic signed [32:0] r2_dx, r2_dy;
    logic signed [65:0] r2_dx2, r2_dy2;
    logic        [63:0] r2_d1, r2_d2;
    logic        [61:0] r2_rr;

    // stage 3: dr2, root sign, magnitudes
    logic [MUL_W-1:0] r3_dr2;
    logic             r3_far;
    logic [63:0]      r3_detm;
    logic             r3_detn;
    logic [32:0]      r3_dxm, r3_dym;
    logic             r3_dxn, r3_dyn;
    logic [61:0]      r3_rr;

    // side data through the discriminant multipliers
    logic [MUL_W-1:0] r_ma_dr2  [MUL_LAT];
    logic             r_ma_far  [MUL_LAT];
    logic [63:0]      r_ma_detm [MUL_LAT];
    logic             r_ma_detn [MUL_LAT];
    logic [32:0]      r_ma_dxm  [MUL_LAT];
    logic [32:0]      r_ma_dym  [MUL_LAT];
    logic             r_ma_dxn  [MUL_LAT];
    logic             r_ma_dyn  [MUL_LAT];

    logic [PROD_W-1:0] w_rrdr2, w_det2;

    // square root stages
    logic [DISC_W-1:0]    r_sq_rem  [SQRT_BITS+1];
    logic [SQRT_BITS-1:0] r_sq_root [SQRT_BITS+1];
    logic [MUL_W-1:0]     r_sq_dr2  [SQRT_BITS+1];
    logic                 r_sq_far  [SQRT_BITS+1];
    logic                 r_sq_nf   [SQRT_BITS+1];
    logic [63:0]          r_sq_detm [SQRT_BITS+1];
    logic                 r_sq_detn [SQRT_BITS+1];
    logic [32:0]          r_sq_dxm  [SQRT_BITS+1];
    logic [32:0]          r_sq_dym  [SQRT_BITS+1];
    logic                 r_sq_dxn  [SQRT_BITS+1];
    logic                 r_sq_dyn  [SQRT_BITS+1];

    logic              n_disc_neg;
    logic [DISC_W-1:0] n_disc;

    // side data through the numerator multipliers
    logic [MUL_W-1:0] r_mb_dr2  [MUL_LAT];
    logic             r_mb_nf   [MUL_LAT];
    logic             r_mb_detn [MUL_LAT];
    logic             r_mb_dxn  [MUL_LAT];
    logic             r_mb_dyn  [MUL_LAT];
    logic             r_mb_sn   [MUL_LAT];

    logic [PROD_W-1:0] w_detdy, w_dxs, w_detdx, w_dys;
    logic [SQRT_BITS-1:0] w_s;

    // numerator stage
    logic signed [NUM_W-1:0] r_nx, r_ny;
    logic [MUL_W-1:0]        r_n_dr2;
    logic                    r_n_nf;

    // divider side data and results
    logic              r_dv_nf [DIV_LAT];
    logic signed [31:0] w_qx, w_qy;

    // Advance everything unless a result waits on a stalled receiver
    assign n_en       = !r_vld[TOTAL_LAT-1] || i_out_ready;
    assign o_in_ready = n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r0_in <= i_in_data;

            r1_dx  <= 33'(r0_in.p2_x) - 33'(r0_in.p1_x);
            r1_dy  <= 33'(r0_in.p2_y) - 33'(r0_in.p1_y);
            r1_p12 <= r0_in.p1_x * r0_in.p2_y;
            r1_p21 <= r0_in.p2_x * r0_in.p1_y;
            r1_sx1 <= r0_in.p1_x * r0_in.p1_x;
            r1_sy1 <= r0_in.p1_y * r0_in.p1_y;
            r1_sx2 <= r0_in.p2_x * r0_in.p2_x;
            r1_sy2 <= r0_in.p2_y * r0_in.p2_y;
            r1_rr  <= 62'(r0_in.radius) * 62'(r0_in.radius);

            r2_det <= 65'(r1_p12) - 65'(r1_p21);
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_dx2 <= r1_dx * r1_dx;
            r2_dy2 <= r1_dy * r1_dy;
            r2_d1  <= 64'(r1_sx1) + 64'(r1_sy1);
            r2_d2  <= 64'(r1_sx2) + 64'(r1_sy2);
            r2_rr  <= r1_rr;

            // Take the minus root when the second point lies nearer the centre
            r3_dr2  <= 66'(r2_dx2) + 66'(r2_dy2);
            r3_far  <= r2_d2 < r2_d1;
            r3_detm <= r2_det[64] ? 64'(-r2_det) : 64'(r2_det);
            r3_detn <= r2_det[64];
            r3_dxm  <= r2_dx[32] ? 33'(-r2_dx) : 33'(r2_dx);
            r3_dym  <= r2_dy[32] ? 33'(-r2_dy) : 33'(r2_dy);
            r3_dxn  <= r2_dx[32];
            r3_dyn  <= r2_dy[32];
            r3_rr   <= r2_rr;
        end
    end

    csi_mul u_mul_rrdr2 (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_a   (MUL_W'(r3_rr)),
        .i_b   (r3_dr2),
        .o_p   (w_rrdr2)
    );

    csi_mul u_mul_det2 (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_a   (MUL_W'(r3_detm)),
        .i_b   (MUL_W'(r3_detm)),
        .o_p   (w_det2)
    );

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_ma_dr2[0]  <= r3_dr2;
            r_ma_far[0]  <= r3_far;
            r_ma_detm[0] <= r3_detm;
            r_ma_detn[0] <= r3_detn;
            r_ma_dxm[0]  <= r3_dxm;
            r_ma_dym[0]  <= r3_dym;
            r_ma_dxn[0]  <= r3_dxn;
            r_ma_dyn[0]  <= r3_dyn;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_ma_dr2[i]  <= r_ma_dr2[i-1];
                r_ma_far[i]  <= r_ma_far[i-1];
                r_ma_detm[i] <= r_ma_detm[i-1];
                r_ma_detn[i] <= r_ma_detn[i-1];
                r_ma_dxm[i]  <= r_ma_dxm[i-1];
                r_ma_dym[i]  <= r_ma_dym[i-1];
                r_ma_dxn[i]  <= r_ma_dxn[i-1];
                r_ma_dyn[i]  <= r_ma_dyn[i-1];
            end
        end
    end

    // Discriminant; a negative one or coincident points give no point
    always_comb begin
        n_disc_neg = w_rrdr2 < w_det2;
        n_disc     = w_rrdr2[DISC_W-1:0] - w_det2[DISC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sq_rem[0]  <= n_disc_neg ? '0 : n_disc;
            r_sq_root[0] <= '0;
            r_sq_nf[0]   <= n_disc_neg || (r_ma_dr2[MUL_LAT-1] == '0);
            r_sq_dr2[0]  <= r_ma_dr2[MUL_LAT-1];
            r_sq_far[0]  <= r_ma_far[MUL_LAT-1];
            r_sq_detm[0] <= r_ma_detm[MUL_LAT-1];
            r_sq_detn[0] <= r_ma_detn[MUL_LAT-1];
            r_sq_dxm[0]  <= r_ma_dxm[MUL_LAT-1];
            r_sq_dym[0]  <= r_ma_dym[MUL_LAT-1];
            r_sq_dxn[0]  <= r_ma_dxn[MUL_LAT-1];
            r_sq_dyn[0]  <= r_ma_dyn[MUL_LAT-1];
        end
    end

    // One root bit per stage, from the top: keep it if (root+2^b)^2 fits
    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
        localparam int B = SQRT_BITS - 1 - j;
        logic [DISC_W+1:0]    n_trial;
        logic                 n_take;
        logic [SQRT_BITS-1:0] n_root;

        always_comb begin
            n_trial = ({(DISC_W+2-SQRT_BITS)'(0), r_sq_root[j]} << (B + 1))
                    | ((DISC_W+2)'(1) << (2 * B));
            n_take    = {2'b00, r_sq_rem[j]} >= n_trial;
            n_root    = r_sq_root[j];
            n_root[B] = n_take;
        end

        always_ff @(posedge i_clk) begin
            if (n_en) begin
                r_sq_rem[j+1]  <= n_take ? r_sq_rem[j] - n_trial[DISC_W-1:0] : r_sq_rem[j];
                r_sq_root[j+1] <= n_root;
                r_sq_nf[j+1]   <= r_sq_nf[j];
                r_sq_dr2[j+1]  <= r_sq_dr2[j];
                r_sq_far[j+1]  <= r_sq_far[j];
                r_sq_detm[j+1] <= r_sq_detm[j];
                r_sq_detn[j+1] <= r_sq_detn[j];
                r_sq_dxm[j+1]  <= r_sq_dxm[j];
                r_sq_dym[j+1]  <= r_sq_dym[j];
                r_sq_dxn[j+1]  <= r_sq_dxn[j];
                r_sq_dyn[j+1]  <= r_sq_dyn[j];
            end
        end
    end

    assign w_s = r_sq_root[SQRT_BITS];

    csi_mul u_mul_detdy (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_a   (MUL_W'(r_sq_detm[SQRT_BITS])),
        .i_b   (MUL_W'(r_sq_dym[SQRT_BITS])),
        .o_p   (w_detdy)
    );

    csi_mul u_mul_dxs (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_a   (MUL_W'(r_sq_dxm[SQRT_BITS])),
        .i_b   (MUL_W'(w_s)),
        .o_p   (w_dxs)
    );

    csi_mul u_mul_detdx (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_a   (MUL_W'(r_sq_detm[SQRT_BITS])),
        .i_b   (MUL_W'(r_sq_dxm[SQRT_BITS])),
        .o_p   (w_detdx)
    );

    csi_mul u_mul_dys (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_a   (MUL_W'(r_sq_dym[SQRT_BITS])),
        .i_b   (MUL_W'(w_s)),
        .o_p   (w_dys)
    );

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_mb_dr2[0]  <= r_sq_dr2[SQRT_BITS];
            r_mb_nf[0]   <= r_sq_nf[SQRT_BITS];
            r_mb_detn[0] <= r_sq_detn[SQRT_BITS];
            r_mb_dxn[0]  <= r_sq_dxn[SQRT_BITS];
            r_mb_dyn[0]  <= r_sq_dyn[SQRT_BITS];
            r_mb_sn[0]   <= r_sq_far[SQRT_BITS] && (w_s != '0);
            for (int i = 1; i < MUL_LAT; i++) begin
                r_mb_dr2[i]  <= r_mb_dr2[i-1];
                r_mb_nf[i]   <= r_mb_nf[i-1];
                r_mb_detn[i] <= r_mb_detn[i-1];
                r_mb_dxn[i]  <= r_mb_dxn[i-1];
                r_mb_dyn[i]  <= r_mb_dyn[i-1];
                r_mb_sn[i]   <= r_mb_sn[i-1];
            end

            // x = det*dy + s*dx*sqrt, y = -det*dx + s*dy*sqrt, over dr2
            r_nx <= f_term(w_detdy, r_mb_detn[MUL_LAT-1] ^ r_mb_dyn[MUL_LAT-1])
                  + f_term(w_dxs, r_mb_dxn[MUL_LAT-1] ^ r_mb_sn[MUL_LAT-1]);
            r_ny <= f_term(w_detdx, !(r_mb_detn[MUL_LAT-1] ^ r_mb_dxn[MUL_LAT-1]))
                  + f_term(w_dys, r_mb_dyn[MUL_LAT-1] ^ r_mb_sn[MUL_LAT-1]);
            r_n_dr2 <= r_mb_dr2[MUL_LAT-1];
            r_n_nf  <= r_mb_nf[MUL_LAT-1];

            r_dv_nf[0] <= r_n_nf;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dv_nf[i] <= r_dv_nf[i-1];
            end
        end
    end

    csi_div u_div_x (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (r_nx),
        .i_den (r_n_dr2),
        .o_q   (w_qx)
    );

    csi_div u_div_y (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (r_ny),
        .i_den (r_n_dr2),
        .o_q   (w_qy)
    );

    // Drop the quotients when no point was found
    assign o_out_valid = r_vld[TOTAL_LAT-1];
    assign o_out_data  = '{found: !r_dv_nf[DIV_LAT-1],
                           out_x: r_dv_nf[DIV_LAT-1] ? 32'sd0 : w_qx,
                           out_y: r_dv_nf[DIV_LAT-1] ? 32'sd0 : w_qy};

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    a_sqrt_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_en && r_vld[ST_SQ0-1] |=> r_vld[ST_SQ0])
        else $error("request lost entering the square root");

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_en && r_vld[ST_NUM] |=> r_vld[ST_NUM+1])
        else $error("request lost entering the divider");
`endif

endmodule

>>> tb/circle_segment_intersect_unit_checker.sv
`default_nettype none

module circle_segment_intersect_unit_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  csi_pkg::t_in   i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  csi_pkg::t_out  i_out_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_found_cnt,
    output int             o_miss_cnt
);
    timeunit 1ns;
    timeprecision 1ps;
    import csi_pkg::*;

    typedef logic signed [191:0] t_wide;

    t_out lookahead_q[$];

    // Round to nearest, ties away from zero, then saturate to 32 bits
    function automatic logic [31:0] round_sat_div(t_wide num, t_wide den);
        t_wide mag;
        t_wide quo;
        t_wide rem;
        mag = (num < 0) ? -num : num;
        quo = mag / den;
        rem = mag - quo * den;
        if (2 * rem >= den) begin
            quo = quo + 1;
        end
        if (num < 0) begin
            if (quo > t_wide'(64'h8000_0000)) begin
                quo = t_wide'(64'h8000_0000);
            end
            return -quo[31:0];
        end
        if (quo > t_wide'(64'h7FFF_FFFF)) begin
            quo = t_wide'(64'h7FFF_FFFF);
        end
        return quo[31:0];
    endfunction

    function automatic t_out predict_lookahead(t_in req);
        t_wide x1, y1, x2, y2, dx, dy, rr, dr2, det, disc, root, cand, nx, ny, d1, d2;
        t_out  res;
        res = '0;
        x1 = req.p1_x;
        y1 = req.p1_y;
        x2 = req.p2_x;
        y2 = req.p2_y;
        rr = t_wide'({1'b0, req.radius});
        dx = x2 - x1;
        dy = y2 - y1;
        dr2 = dx * dx + dy * dy;
        det = x1 * y2 - x2 * y1;
        disc = rr * rr * dr2 - det * det;
        // coincident points or a line that misses the circle
        if (dr2 == 0 || disc < 0) begin
            return res;
        end
        root = 0;
        for (int b = 67; b >= 0; b--) begin
            cand = root | (t_wide'(1) << b);
            if (cand * cand <= disc) begin
                root = cand;
            end
        end
        d1 = x1 * x1 + y1 * y1;
        d2 = x2 * x2 + y2 * y2;
        if (d2 < d1) begin
            root = -root;
        end
        nx = det * dy + dx * root;
        ny = -det * dx + dy * root;
        res.found = 1'b1;
        res.out_x = round_sat_div(nx, dr2);
        res.out_y = round_sat_div(ny, dr2);
        return res;
    endfunction

    assign o_pending = lookahead_q.size();

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            lookahead_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                lookahead_q.push_back(predict_lookahead(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (lookahead_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = lookahead_q.pop_front();
                    if (want.found) o_found_cnt <= o_found_cnt + 1;
                    else o_miss_cnt <= o_miss_cnt + 1;
                    if (want.found !== i_out_data.found || want.out_x !== i_out_data.out_x
                        || want.out_y !== i_out_data.out_y) begin
                        $display("%0t: mismatch expected found=%0b x=%h y=%h, got found=%0b x=%h y=%h",
                                 $time, want.found, want.out_x, want.out_y,
                                 i_out_data.found, i_out_data.out_x, i_out_data.out_y);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    initial begin
        o_errors = 0;
        o_found_cnt = 0;
        o_miss_cnt = 0;
    end

endmodule

`default_nettype wire

>>> tb/circle_segment_intersect_unit_tb.sv
`default_nettype none

module circle_segment_intersect_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csi_pkg::*;

    localparam int N_RANDOM   = 2000;
    localparam int IDLE_LIMIT = 4000;   // long output hold-offs plus pipeline depth fit well inside
    localparam int DRAIN_WAIT = 200;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    int errors, pending, found_cnt, miss_cnt;
    int idle_cycles;
    int results_seen;

    circle_segment_intersect_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Watch both channels, predict every request and compare results
    circle_segment_intersect_unit_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_found_cnt (found_cnt),
        .o_miss_cnt  (miss_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: end the run when no request and no result moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("circle_segment_intersect_unit_tb failed");
                $finish;
            end
        end
    end

    // Receiver: stall on its own random pattern, with two long hold-offs so
    // the pipeline fills and the input channel backs up
    initial begin
        int hold;
        int mode;
        hold = 0;
        results_seen = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) results_seen++;
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if (results_seen == 300 || results_seen == 1500) begin
                hold = 500;
                results_seen++;
                i_out_ready <= 1'b0;
            end else begin
                // alternate stretches of full speed and random stalls
                mode = (results_seen / 100) % 3;
                if (mode == 0) i_out_ready <= 1'b1;
                else if (mode == 1) i_out_ready <= ($urandom_range(0, 3) != 0);
                else i_out_ready <= 1'($urandom_range(0, 1));
            end
        end
    end

    function automatic logic signed [31:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: begin
                return $urandom;
            end
            3, 4, 5, 6: begin
                return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            end
            7: begin
                return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            end
            8: begin
                return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end
            default: begin
                return $signed($urandom_range(0, 32)) - 32'sd16;
            end
        endcase
    endfunction

    function automatic t_in rand_request();
        t_in req;
        req.p1_x = rand_coord();
        req.p1_y = rand_coord();
        case ($urandom_range(0, 5))
            0: begin
                // coincident or nearly coincident points
                req.p2_x = req.p1_x + $signed($urandom_range(0, 2)) - 1;
                req.p2_y = req.p1_y + $signed($urandom_range(0, 2)) - 1;
            end
            1: begin
                req.p2_x = -req.p1_x;
                req.p2_y = -req.p1_y;
            end
            default: begin
                req.p2_x = rand_coord();
                req.p2_y = rand_coord();
            end
        endcase
        case ($urandom_range(0, 3))
            0: req.radius = 31'($urandom);
            1: req.radius = 31'($urandom_range(0, 31'h0040_0000));
            2: req.radius = 31'($urandom_range(0, 31'h0400_0000));
            default: req.radius = 31'($urandom_range(0, 64));
        endcase
        return req;
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_request(t_in req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid for a random gap, sometimes
    task automatic sender_gap();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_directed(logic signed [31:0] ax, logic signed [31:0] ay,
                                 logic signed [31:0] bx, logic signed [31:0] by,
                                 logic [30:0] rad);
        t_in req;
        req = '{p1_x: ax, p1_y: ay, p2_x: bx, p2_y: by, radius: rad};
        send_request(req);
    endtask

    initial begin
        int burst;
        int sent;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zeros, coincident points, miss, tangent, both root
        // choices, zero radius, full-scale extremes and saturation
        send_directed(0, 0, 0, 0, 0);
        send_directed(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000,
                      31'h0001_0000);
        send_directed(32'sh000A_0000, 32'sh000A_0000, 32'sh000B_0000, 32'sh000A_0000,
                      31'h0001_0000);
        send_directed(-32'sh0005_0000, 32'sh0001_0000, 32'sh0005_0000, 32'sh0001_0000,
                      31'h0001_0000);
        send_directed(-32'sh0005_0000, 0, 32'sh0005_0000, 0, 31'h0002_0000);
        send_directed(32'sh0005_0000, 0, -32'sh0005_0000, 0, 31'h0002_0000);
        send_directed(32'sh0003_0000, 0, -32'sh0003_0000, 0, 31'h0003_0000);
        send_directed(0, 0, 32'sh0001_0000, 32'sh0001_0000, 0);
        send_directed(32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0001_0000, 0);
        send_directed(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                      31'h7FFF_FFFF);
        send_directed(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                      31'h7FFF_FFFF);
        send_directed(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
        send_directed(0, 0, 1, 0, 31'h7FFF_FFFF);
        send_directed(0, 0, 0, 1, 31'h7FFF_FFFF);
        send_directed(-1, -1, 0, -1, 31'h7FFF_FFFF);
        send_directed(32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFE, 0, 31'h7FFF_FFFF);
        send_directed(1, 1, 1, 1, 31'h7FFF_FFFF);
        send_directed(-32'sh0000_0003, 32'sh0000_0001, 32'sh0000_0004, 32'sh0000_0001, 2);
        send_directed(32'sh8000_0000, 0, 0, 32'sh8000_0000, 31'h5A82_7999);
        i_in_valid <= 1'b0;

        // Let the pipeline empty before the random traffic
        wait (pending == 0);
        @(posedge i_clk);

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
                send_request(rand_request());
                sent++;
                if (k % 8 == 7) sender_gap();
            end
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(posedge i_clk);
            if (sent == 1000 || (sent > 1000 && sent - burst < 1000)) begin
                // drain completely once mid-run
                wait (pending == 0);
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d results: %0d with a point, %0d with none.",
                 found_cnt + miss_cnt, found_cnt, miss_cnt);
        $display("Traffic had bursts, gaps, random stalls and two long output hold-offs.");
        if (errors == 0 && pending == 0) begin
            $display("circle_segment_intersect_unit_tb passed");
        end else begin
            $display("circle_segment_intersect_unit_tb failed");
        end
        $finish;
    end

    initial idle_cycles = 0;

endmodule

`default_nettype wire

>>> files.f
rtl/csi_pkg.sv
rtl/csi_mul.sv
rtl/csi_div.sv
rtl/circle_segment_intersect_unit.sv
tb/circle_segment_intersect_unit_checker.sv
tb/circle_segment_intersect_unit_tb.sv
